[rtl/mrt_peer_index_table_parser_defines.svh]
// Assertion macros for the peer index table parser.
`ifndef MRT_PEER_INDEX_TABLE_PARSER_DEFINES_SVH
`define MRT_PEER_INDEX_TABLE_PARSER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/mrt_pkg.sv]
// Shared types and constants of the peer index table parser.
package mrt_pkg;
  localparam logic [7:0] TYPE_IPV6 = 8'h01;
  localparam logic [7:0] TYPE_AS4 = 8'h02;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PEER   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Byte word carried through the front part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_end;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] peer_number;
    logic        is_ipv6;
    logic        is_as4;
    logic [31:0] router_id;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] as_number;
    logic [15:0] name_length;
    logic [15:0] entry_total;
    logic        table_done;
  } out_word_t;
endpackage

[rtl/mrt_if.sv]
// Valid/ready channel interfaces for input bytes and results.
interface mrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_end;
  modport source (output valid, data_byte, record_end, input ready);
  modport sink (input valid, data_byte, record_end, output ready);
endinterface

interface mrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] peer_number;
  logic        is_ipv6;
  logic        is_as4;
  logic [31:0] router_id;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [31:0] as_number;
  logic [15:0] name_length;
  logic [15:0] entry_total;
  logic        table_done;
  modport source (output valid, kind, peer_number, is_ipv6, is_as4, router_id,
                  address_high, address_low, as_number, name_length, entry_total,
                  table_done, input ready);
  modport sink (input valid, kind, peer_number, is_ipv6, is_as4, router_id,
                address_high, address_low, as_number, name_length, entry_total,
                table_done, output ready);
endinterface

[rtl/mrt_queue.sv]
// Small word queue between the front and back parts.
module mrt_queue #(
  parameter int DEPTH = mrt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  mrt_pkg::in_word_t wr_word,
  output logic              rd_valid,
  input  logic              rd_ready,
  output mrt_pkg::in_word_t rd_word
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mrt_pkg::in_word_t  mem_r [DEPTH];
  logic [AW-1:0]      wp_r, rp_r;
  logic [AW:0]        cnt_r;
  logic               push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_word  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  // Storage for queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[rtl/mrt_parse.sv]
// Back part: byte-wise field parser with an output register.
module mrt_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrt_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output mrt_pkg::out_word_t out_word
);
  typedef enum logic [3:0] {
    PH_COLLECTOR, PH_NAMELEN, PH_NAME, PH_COUNT, PH_TYPE,
    PH_PEERID, PH_ADDR, PH_AS, PH_TRAILER
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [15:0]   name_left_r, name_left_nxt;
  logic [15:0]   peers_left_r, peers_left_nxt;
  logic [15:0]   cur_peer_r, cur_peer_nxt;
  logic [63:0]   hdr_r, hdr_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [63:0]   addr_hi_r, addr_hi_nxt, addr_lo_r, addr_lo_nxt;
  logic [31:0]   as_r, as_nxt;
  logic [1:0]    flags_r, flags_nxt;
  logic          res_v;
  mrt_pkg::out_word_t res;
  logic          out_valid_r;
  mrt_pkg::out_word_t out_word_r;
  logic          take;
  logic [7:0]    b;
  logic [4:0]    cnt_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign b         = in_word.data_byte;
  assign cnt_inc   = cnt_r + 5'd1;

  // Next-state logic for one byte.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    name_left_nxt = name_left_r;
    peers_left_nxt = peers_left_r;
    cur_peer_nxt = cur_peer_r;
    hdr_nxt = hdr_r;
    id_nxt = id_r;
    addr_hi_nxt = addr_hi_r;
    addr_lo_nxt = addr_lo_r;
    as_nxt = as_r;
    flags_nxt = flags_r;
    res_v = 1'b0;
    res = '0;
    case (phase_r)
      PH_COLLECTOR, PH_NAMELEN, PH_COUNT: begin
        hdr_nxt = {hdr_r[55:0], b};
        cnt_nxt = cnt_inc;
        if (phase_r == PH_COLLECTOR && cnt_inc >= 5'd4) begin
          phase_nxt = PH_NAMELEN;
          cnt_nxt = '0;
        end else if (phase_r == PH_NAMELEN && cnt_inc >= 5'd2) begin
          name_left_nxt = hdr_nxt[15:0];
          phase_nxt = (hdr_nxt[15:0] != '0) ? PH_NAME : PH_COUNT;
          cnt_nxt = '0;
        end else if (phase_r == PH_COUNT && cnt_inc >= 5'd2) begin
          cnt_nxt = '0;
          peers_left_nxt = hdr_nxt[15:0];
          cur_peer_nxt = '0;
          phase_nxt = (hdr_nxt[15:0] != '0) ? PH_TYPE : PH_TRAILER;
          res_v = 1'b1;
          res.kind = mrt_pkg::KIND_HEADER;
          res.router_id = hdr_nxt[63:32];
          res.name_length = hdr_nxt[31:16];
          res.entry_total = hdr_nxt[15:0];
          res.table_done = (hdr_nxt[15:0] == '0);
        end
      end
      PH_NAME: begin
        name_left_nxt = name_left_r - 16'd1;
        if (name_left_nxt == '0) begin
          phase_nxt = PH_COUNT;
          cnt_nxt = '0;
        end
      end
      PH_TYPE: begin
        flags_nxt = b[1:0] & (mrt_pkg::TYPE_IPV6[1:0] | mrt_pkg::TYPE_AS4[1:0]);
        id_nxt = '0;
        addr_hi_nxt = '0;
        addr_lo_nxt = '0;
        as_nxt = '0;
        cnt_nxt = '0;
        phase_nxt = PH_PEERID;
      end
      PH_PEERID: begin
        id_nxt = {id_r[23:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 5'd4) begin
          cnt_nxt = '0;
          phase_nxt = PH_ADDR;
        end
      end
      PH_ADDR: begin
        addr_hi_nxt = {addr_hi_r[55:0], addr_lo_r[63:56]};
        addr_lo_nxt = {addr_lo_r[55:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= (flags_r[0] ? 5'd16 : 5'd4)) begin
          cnt_nxt = '0;
          phase_nxt = PH_AS;
        end
      end
      PH_AS: begin
        as_nxt = {as_r[23:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= (flags_r[1] ? 5'd4 : 5'd2)) begin
          cnt_nxt = '0;
          peers_left_nxt = peers_left_r - 16'd1;
          cur_peer_nxt = cur_peer_r + 16'd1;
          phase_nxt = (peers_left_nxt != '0) ? PH_TYPE : PH_TRAILER;
          res_v = 1'b1;
          res.kind = mrt_pkg::KIND_PEER;
          res.peer_number = cur_peer_r;
          res.is_ipv6 = flags_r[0];
          res.is_as4 = flags_r[1];
          res.router_id = id_r;
          res.address_high = addr_hi_nxt;
          res.address_low = addr_lo_nxt;
          res.as_number = as_nxt;
          res.name_length = hdr_r[31:16];
          res.entry_total = hdr_r[15:0];
          res.table_done = (peers_left_nxt == '0);
        end
      end
      default: begin
        phase_nxt = PH_TRAILER;
      end
    endcase
    // A record end restarts the parser and, unless the table was complete, reports truncation.
    if (in_word.record_end) begin
      if (phase_nxt != PH_TRAILER) begin
        res_v = 1'b1;
        res = '0;
        res.kind = mrt_pkg::KIND_ERROR;
        res.peer_number = cur_peer_nxt;
        res.table_done = 1'b1;
      end
      phase_nxt = PH_COLLECTOR;
      cnt_nxt = '0;
      name_left_nxt = '0;
      peers_left_nxt = '0;
      cur_peer_nxt = '0;
      hdr_nxt = '0;
      id_nxt = '0;
      addr_hi_nxt = '0;
      addr_lo_nxt = '0;
      as_nxt = '0;
      flags_nxt = '0;
    end
  end

  // Parser state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COLLECTOR;
      cnt_r <= '0;
      name_left_r <= '0;
      peers_left_r <= '0;
      cur_peer_r <= '0;
      hdr_r <= '0;
      id_r <= '0;
      addr_hi_r <= '0;
      addr_lo_r <= '0;
      as_r <= '0;
      flags_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        cnt_r <= cnt_nxt;
        name_left_r <= name_left_nxt;
        peers_left_r <= peers_left_nxt;
        cur_peer_r <= cur_peer_nxt;
        hdr_r <= hdr_nxt;
        id_r <= id_nxt;
        addr_hi_r <= addr_hi_nxt;
        addr_lo_r <= addr_lo_nxt;
        as_r <= as_nxt;
        flags_r <= flags_nxt;
      end
      if (in_ready) begin
        out_valid_r <= take && res_v;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take && res_v) begin
      out_word_r <= res;
    end
  end
endmodule

[rtl/mrt_peer_index_table_parser.sv]
// Top level of the peer index table parser.
// Throughput: one byte per cycle while the result output is not stalled; the parser handles each byte as it is taken.
// A result is registered in the parser's output register when the parser takes its last byte from the queue.
// Reset: synchronous active-low rst_n clears the queue, parser state and output valid.
// Every byte flagged as record end returns the parser to its reset state.
`include "mrt_peer_index_table_parser_defines.svh"
module mrt_peer_index_table_parser #(
  parameter int QUEUE_DEPTH = mrt_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  mrt_in_if.sink    in_ch,
  mrt_out_if.source out_ch
);
  mrt_pkg::in_word_t  fw, bw;
  mrt_pkg::out_word_t ow;
  logic               bv, br;

  assign fw.data_byte  = in_ch.data_byte;
  assign fw.record_end = in_ch.record_end;

  // Front part: queue of incoming bytes.
  mrt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_ch.valid), .wr_ready(in_ch.ready), .wr_word(fw),
    .rd_valid(bv), .rd_ready(br), .rd_word(bw)
  );

  // Back part: field parser.
  mrt_parse u_parse (
    .clk(clk), .rst_n(rst_n),
    .in_valid(bv), .in_ready(br), .in_word(bw),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(ow)
  );

  assign out_ch.kind         = ow.kind;
  assign out_ch.peer_number  = ow.peer_number;
  assign out_ch.is_ipv6      = ow.is_ipv6;
  assign out_ch.is_as4       = ow.is_as4;
  assign out_ch.router_id    = ow.router_id;
  assign out_ch.address_high = ow.address_high;
  assign out_ch.address_low  = ow.address_low;
  assign out_ch.as_number    = ow.as_number;
  assign out_ch.name_length  = ow.name_length;
  assign out_ch.entry_total  = ow.entry_total;
  assign out_ch.table_done   = ow.table_done;

  // Checks on the result stream.
  `MRT_ASSERT_IMP(a_err_done, out_ch.valid && out_ch.kind == mrt_pkg::KIND_ERROR,
    out_ch.table_done, "error word without table_done")
  `MRT_ASSERT_IMP(a_kind_legal, out_ch.valid, out_ch.kind <= mrt_pkg::KIND_ERROR,
    "illegal kind")
  `MRT_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.router_id), "stalled word changed")
endmodule

[dv/tb_top.sv]
// Self-checking testbench for the peer index table parser: bytes in, results checked.
`timescale 1ns / 100ps
module tb_top;

  localparam int PAUSE_IDX = 600;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_end;
  } rec_byte_t;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    P_COLLECTOR, P_NAMELEN, P_NAME, P_COUNT, P_TYPE, P_PEERID, P_ADDR, P_AS,
    P_TRAILER
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mrt_in_if in_ch();
  mrt_out_if out_ch();

  mrt_peer_index_table_parser DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  rec_byte_t pending_bytes[$];
  mrt_pkg::out_word_t expected_results[$];
  int mismatches = 0;
  int sent_count = 0;
  bit stimulus_done = 1'b0;
  bit pause_req = 1'b0;

  // Predictor state.
  parse_phase_t ph;
  logic [4:0] bcnt;
  logic [15:0] name_left, peers_left, cur_peer;
  logic [63:0] hdr;
  logic [31:0] pid_sr, as_sr;
  logic [63:0] addr_hi_sr, addr_lo_sr;
  logic [1:0] flags;

  task automatic clear_parser();
    ph = P_COLLECTOR; bcnt = '0; name_left = '0; peers_left = '0; cur_peer = '0;
    hdr = '0; pid_sr = '0; as_sr = '0; addr_hi_sr = '0; addr_lo_sr = '0; flags = '0;
  endtask

  // Advance the predictor by one byte and queue any result it yields.
  task automatic parse_byte(input rec_byte_t rb);
    mrt_pkg::out_word_t r;
    bit have;
    logic [15:0] nlen, tot;
    have = 1'b0;
    r = '0;
    nlen = hdr[31:16];
    tot = hdr[15:0];
    case (ph)
      P_COLLECTOR, P_NAMELEN, P_COUNT: begin
        hdr = {hdr[55:0], rb.data_byte};
        bcnt++;
        if (ph == P_COLLECTOR && bcnt >= 4) begin
          ph = P_NAMELEN; bcnt = '0;
        end else if (ph == P_NAMELEN && bcnt >= 2) begin
          name_left = hdr[15:0];
          ph = (name_left != 0) ? P_NAME : P_COUNT;
          bcnt = '0;
        end else if (ph == P_COUNT && bcnt >= 2) begin
          bcnt = '0;
          peers_left = hdr[15:0];
          cur_peer = '0;
          ph = (peers_left != 0) ? P_TYPE : P_TRAILER;
          r.kind = mrt_pkg::KIND_HEADER;
          r.router_id = hdr[63:32];
          r.name_length = hdr[31:16];
          r.entry_total = hdr[15:0];
          r.table_done = (peers_left == 0);
          have = 1'b1;
        end
      end
      P_NAME: begin
        name_left--;
        if (name_left == 0) begin
          ph = P_COUNT; bcnt = '0;
        end
      end
      P_TYPE: begin
        flags = rb.data_byte[1:0] & (mrt_pkg::TYPE_IPV6[1:0] | mrt_pkg::TYPE_AS4[1:0]);
        pid_sr = '0; addr_hi_sr = '0; addr_lo_sr = '0; as_sr = '0; bcnt = '0;
        ph = P_PEERID;
      end
      P_PEERID: begin
        pid_sr = {pid_sr[23:0], rb.data_byte};
        bcnt++;
        if (bcnt >= 4) begin
          bcnt = '0; ph = P_ADDR;
        end
      end
      P_ADDR: begin
        addr_hi_sr = {addr_hi_sr[55:0], addr_lo_sr[63:56]};
        addr_lo_sr = {addr_lo_sr[55:0], rb.data_byte};
        bcnt++;
        if (bcnt >= ((flags & mrt_pkg::TYPE_IPV6[1:0]) != 0 ? 16 : 4)) begin
          bcnt = '0; ph = P_AS;
        end
      end
      P_AS: begin
        as_sr = {as_sr[23:0], rb.data_byte};
        bcnt++;
        if (bcnt >= ((flags & mrt_pkg::TYPE_AS4[1:0]) != 0 ? 4 : 2)) begin
          bcnt = '0;
          peers_left--;
          r.kind = mrt_pkg::KIND_PEER;
          r.peer_number = cur_peer;
          r.is_ipv6 = flags[0];
          r.is_as4 = flags[1];
          r.router_id = pid_sr;
          r.address_high = addr_hi_sr;
          r.address_low = addr_lo_sr;
          r.as_number = as_sr;
          r.name_length = nlen;
          r.entry_total = tot;
          r.table_done = (peers_left == 0);
          have = 1'b1;
          cur_peer++;
          ph = (peers_left != 0) ? P_TYPE : P_TRAILER;
        end
      end
      default: ph = P_TRAILER;
    endcase
    // A record end always resets; an unfinished table reports an error instead.
    if (rb.record_end) begin
      if (ph != P_TRAILER) begin
        r = '0;
        r.kind = mrt_pkg::KIND_ERROR;
        r.peer_number = cur_peer;
        r.table_done = 1'b1;
        have = 1'b1;
      end
      clear_parser();
    end
    if (have) expected_results.insert(expected_results.size(), r);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic e);
    rec_byte_t rb;
    rb.data_byte = b;
    rb.record_end = e;
    pending_bytes.insert(pending_bytes.size(), rb);
  endtask

  task automatic add_bytes(input int v, input int width);
    for (int i = width - 1; i >= 0; i--) add_byte(8'(v >> (8 * i)), 1'b0);
  endtask

  // Build a table record; 0 <= cut_at < record size ends the record early, keeping bytes 0 to cut_at.
  task automatic add_record(input int npeers, input int name_len, input int trailer,
                            input int cut_at, input bit rand_types);
    rec_byte_t rec[$];
    rec_byte_t rb;
    int typ, alen, aslen;
    rb.record_end = 1'b0;
    for (int i = 0; i < 4; i++) begin
      rb.data_byte = 8'($urandom); rec.insert(rec.size(), rb);
    end
    rb.data_byte = 8'(name_len >> 8); rec.insert(rec.size(), rb);
    rb.data_byte = 8'(name_len); rec.insert(rec.size(), rb);
    for (int i = 0; i < name_len; i++) begin
      rb.data_byte = 8'($urandom); rec.insert(rec.size(), rb);
    end
    rb.data_byte = 8'(npeers >> 8); rec.insert(rec.size(), rb);
    rb.data_byte = 8'(npeers); rec.insert(rec.size(), rb);
    for (int p = 0; p < npeers; p++) begin
      typ = rand_types ? $urandom : p;
      rb.data_byte = 8'(typ); rec.insert(rec.size(), rb);
      alen = typ[0] ? 16 : 4;
      aslen = typ[1] ? 4 : 2;
      for (int i = 0; i < 4 + alen + aslen; i++) begin
        rb.data_byte = 8'($urandom); rec.insert(rec.size(), rb);
      end
    end
    for (int i = 0; i < trailer; i++) begin
      rb.data_byte = 8'($urandom); rec.insert(rec.size(), rb);
    end
    if (cut_at >= 0 && cut_at < rec.size()) rec = rec[0:cut_at];
    rec[rec.size() - 1].record_end = 1'b1;
    pending_bytes = {pending_bytes, rec};
  endtask

  // Stimulus: directed records, then random ones with some noise.
  initial begin
    int c;
    clear_parser();
    add_record(0, 0, 0, -1, 1'b0);
    add_record(4, 2, 2, -1, 1'b0);
    add_record(2, 1, 0, 3, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_bytes(32'hFFFF_FFFF, 4);
    add_byte(8'h00, 1'b1);
    while (pending_bytes.size() < 1200) begin
      c = $urandom_range(0, 9);
      if (c < 6) add_record($urandom_range(0, 4), $urandom_range(0, 3),
                            $urandom_range(0, 2), -1, 1'b1);
      else if (c < 9) add_record($urandom_range(1, 4), $urandom_range(0, 3), 0,
                                 $urandom_range(0, 60), 1'b1);
      else for (int i = $urandom_range(1, 6); i > 0; i--)
        add_byte(8'($urandom), ($urandom_range(0, 5) == 0));
    end
    add_byte(8'h00, 1'b1);
  end

  // Input acceptance as seen at the rising edge.
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: bursts with random gaps, plus one pause until all results drain.
  int burst_left = 0, gap_left = 0;
  rec_byte_t cur;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        parse_byte(cur);
        void'(pending_bytes.pop_front());
        sent_count++;
        if (sent_count == PAUSE_IDX) pause_req = 1'b1;
      end
      if (pause_req && expected_results.size() == 0) pause_req = 1'b0;
      if (in_ch.valid && !in_taken) begin
        // A waiting word stays on the bus until it is taken.
      end else begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (pending_bytes.size() == 0) begin
          in_ch.valid <= 1'b0;
          stimulus_done = 1'b1;
        end else if (pause_req || gap_left > 0) begin
          in_ch.valid <= 1'b0;
          if (!pause_req) gap_left--;
        end else begin
          cur = pending_bytes[0];
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= cur.data_byte;
          in_ch.record_end <= cur.record_end;
          burst_left--;
        end
      end
    end
  end

  // Receiver stall pattern: a slowly varying duty cycle.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase[9:8] == 2'd0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) < stall_phase[9:8]);
  end

  // Monitor: compare every accepted result word with the oldest expectation.
  mrt_pkg::out_word_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{kind: out_ch.kind, peer_number: out_ch.peer_number, is_ipv6: out_ch.is_ipv6,
              is_as4: out_ch.is_as4, router_id: out_ch.router_id,
              address_high: out_ch.address_high, address_low: out_ch.address_low,
              as_number: out_ch.as_number, name_length: out_ch.name_length,
              entry_total: out_ch.entry_total, table_done: out_ch.table_done};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Reset, drain, and verdict.
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.record_end = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (stimulus_done && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/mrt_pkg.sv
rtl/mrt_if.sv
rtl/mrt_queue.sv
rtl/mrt_parse.sv
rtl/mrt_peer_index_table_parser.sv
dv/tb_top.sv
